// File: rtl/sha_pkg.sv
// SHA-256 package: shared types, round constants, initial hash values and the rotate and schedule functions.
// Used by all modules of the sha256_digest block; depends on nothing.
package sha_pkg;

  // Queue entry from the front: one message byte and its flags.
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } sha_item_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } sha_state_e;

  localparam int unsigned QueueDepth = 4;

  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    logic [31:0] r;
    unique case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// File: rtl/sha_queue.sv
// Short byte queue between the input front and the hash core.
// Depends on sha_pkg for the entry type and depth.
module sha_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sha_pkg::sha_item_t in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sha_pkg::sha_item_t out_item_o
);
  import sha_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  sha_item_t          mem_q [QueueDepth];
  logic [PtrW-1:0]    wr_q, rd_q;
  logic [PtrW:0]      cnt_q;
  logic               push, pop;

  assign in_ready_o  = (cnt_q != (PtrW+1)'(QueueDepth));
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  // Write storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_item_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// File: rtl/sha_core.sv
// Hash core: block buffer, message schedule, one compression round per cycle,
// padding and digest output. Depends on sha_pkg.
module sha_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  sha_pkg::sha_item_t item_i,
  output logic               digest_valid_o,
  input  logic               digest_ready_i,
  output logic [31:0]        digest_word_o,
  output logic [2:0]         word_index_o,
  output logic               last_word_o
);
  import sha_pkg::*;

  sha_state_e  state_q, state_d;
  logic [31:0] win_q [16];       // schedule window, word 0 is current
  logic [31:0] h_q [8];          // chaining words
  logic [31:0] v_q [8];          // working variables
  logic [60:0] count_q;
  logic [5:0]  rnd_q;
  logic [2:0]  idx_q;
  logic        closing_q;        // closing sequence in progress
  logic        marked_q;         // 0x80 already placed
  logic        len_q;            // current block carries the length
  logic [5:0]  pos_q;            // fill position while padding
  logic [63:0] bits_q;

  logic [31:0] t1, t2, wnew, big0, big1, ch, maj;
  logic        take, put_byte;
  logic [7:0]  put_val;

  assign item_ready_o = (state_q == ST_LOAD) && !closing_q;
  assign take = item_valid_i && item_ready_o;

  // Round datapath
  always_comb begin
    big1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    big0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1   = v_q[7] + big1 + ch + RoundK[rnd_q] + win_q[0];
    t2   = big0 + maj;
    wnew = win_q[0] + sig0(win_q[1]) + win_q[9] + sig1(win_q[14]);
  end

  // Choose byte written into the buffer this cycle
  always_comb begin
    put_byte = 1'b0;
    put_val  = 8'h00;
    if (state_q == ST_LOAD && take && item_i.present) begin
      put_byte = 1'b1;
      put_val  = item_i.data;
    end else if (state_q == ST_PAD) begin
      put_byte = 1'b1;
      if (!marked_q) put_val = 8'h80;
      else if (len_q && pos_q >= 6'd56) put_val = bits_q[8*(63-pos_q) +: 8];
      else put_val = 8'h00;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (closing_q) state_d = ST_PAD;
        else if (take && item_i.present && count_q[5:0] == 6'd63) state_d = ST_ROUND;
        else if (take && item_i.last) state_d = ST_PAD;
      end
      ST_ROUND: if (rnd_q == 6'd63) state_d = ST_ADD;
      ST_ADD:   state_d = (closing_q && len_q) ? ST_EMIT : (closing_q ? ST_PAD : ST_LOAD);
      ST_PAD:   if (pos_q == 6'd63) state_d = ST_ROUND;
      ST_EMIT:  if (digest_ready_i && idx_q == 3'd7) state_d = ST_LOAD;
      default:  state_d = ST_LOAD;
    endcase
  end

  // Buffer: shift bytes into window word 15 big-endian; rounds shift words
  always_ff @(posedge clk_i) begin
    if (put_byte) begin
      for (int i = 0; i < 15; i++) win_q[i] <= {win_q[i][23:0], win_q[i+1][31:24]};
      win_q[15] <= {win_q[15][23:0], put_val};
    end else if (state_q == ST_ROUND) begin
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
      win_q[15] <= wnew;
    end
    if (state_q == ST_ROUND) begin
      v_q[0] <= t1 + t2;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3] + t1;
      v_q[5] <= v_q[4];
      v_q[6] <= v_q[5];
      v_q[7] <= v_q[6];
    end else begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end
  end

  // Control registers and chaining words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      count_q   <= '0;
      rnd_q     <= '0;
      idx_q     <= '0;
      closing_q <= 1'b0;
      marked_q  <= 1'b0;
      len_q     <= 1'b0;
      pos_q     <= '0;
      bits_q    <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
    end else begin
      state_q <= state_d;
      if (take && item_i.present) count_q <= count_q + 1'b1;
      if (take && item_i.last) begin
        closing_q <= 1'b1;
        marked_q  <= 1'b0;
      end
      // Enter padding: decide whether this block holds the length
      if (state_q != ST_PAD && state_d == ST_PAD) begin
        pos_q  <= count_q[5:0] + ((take && item_i.present) ? 6'd1 : 6'd0);
        bits_q <= {count_q + ((take && item_i.present) ? 61'd1 : 61'd0), 3'b000};
        if (marked_q) begin
          pos_q <= '0;
          len_q <= 1'b1;
        end else begin
          len_q <= ((count_q[5:0] + ((take && item_i.present) ? 6'd1 : 6'd0)) < 6'd56);
        end
      end
      if (state_q == ST_PAD) begin
        marked_q <= 1'b1;
        pos_q    <= pos_q + 1'b1;
      end
      if (state_q == ST_ROUND) rnd_q <= rnd_q + 1'b1;
      if (state_q == ST_ADD) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (state_q == ST_EMIT && digest_ready_i) begin
        idx_q <= idx_q + 1'b1;
        if (idx_q == 3'd7) begin
          for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
          count_q   <= '0;
          closing_q <= 1'b0;
          marked_q  <= 1'b0;
          len_q     <= 1'b0;
        end
      end
    end
  end

  assign digest_valid_o = (state_q == ST_EMIT);
  assign digest_word_o  = h_q[idx_q];
  assign word_index_o   = idx_q;
  assign last_word_o    = (idx_q == 3'd7);

endmodule

// File: rtl/sha256_digest.sv
// Top level of the streaming SHA-256 block: input queue and hash core.
// Depends on sha_pkg, sha_queue and sha_core.
// Takes the message one byte per word through a four-entry queue. Every
// 64th byte starts a compression of 64 rounds and an add step, during
// which the core takes no bytes. A final word adds padding up to the end of
// the block and a compression, and, when fewer than 9 bytes were free, a
// second padded block and compression; then eight digest words follow, word
// 0 first, and the core reloads the initial hash.
module sha256_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  message_byte_i,
  input  logic        byte_present_i,
  input  logic        final_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sha_pkg::*;

  sha_item_t in_item, q_item;
  logic      q_valid, q_ready;

  assign in_item = '{data: message_byte_i, present: byte_present_i, last: final_item_i};

  sha_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_item_o  (q_item)
  );

  sha_core u_core (
    .clk_i, .rst_ni,
    .item_valid_i   (q_valid),
    .item_ready_o   (q_ready),
    .item_i         (q_item),
    .digest_valid_o (out_valid_o),
    .digest_ready_i (out_ready_i),
    .digest_word_o  (digest_word_o),
    .word_index_o   (word_index_o),
    .last_word_o    (last_word_o)
  );

endmodule
